FILE: rtl/iee_pkg.sv
// Shared types and codes for the infix expression evaluator.
// Used by the front classifier, the item queue, the execution engine and the top level.
package iee_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_expr;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
    } out_item_t;

    // Classified token kinds.
    typedef enum logic [2:0] {
        TK_NONE  = 3'd0,
        TK_DIGIT = 3'd1,
        TK_OP    = 3'd2,
        TK_LPAR  = 3'd3,
        TK_RPAR  = 3'd4
    } tok_kind_t;

    // Operator stack codes.
    localparam logic [2:0] OP_LPAR = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

    localparam logic [7:0] CH_ADD  = 8'h2B;
    localparam logic [7:0] CH_SUB  = 8'h2D;
    localparam logic [7:0] CH_MUL  = 8'h2A;
    localparam logic [7:0] CH_DIV  = 8'h2F;
    localparam logic [7:0] CH_LPAR = 8'h28;
    localparam logic [7:0] CH_RPAR = 8'h29;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // One classified token as it travels through the queue.
    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] digit;
        logic [2:0] op;
        logic       last;
    } token_t;

    function automatic logic op_high(input logic [2:0] op);
        return (op == OP_MUL) || (op == OP_DIV);
    endfunction

endpackage

FILE: rtl/iee_front.sv
// Front end: accepts characters and classifies them into tokens.
// Depends on iee_pkg.
module iee_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  iee_pkg::in_item_t s_data,
    output logic              t_valid,
    input  logic              t_ready,
    output iee_pkg::token_t   t_data
);
    import iee_pkg::*;

    token_t tok_reg, tok_next;
    logic   valid_reg;

    assign s_ready = !valid_reg || t_ready;
    assign t_valid = valid_reg;
    assign t_data  = tok_reg;

    always_comb begin
        tok_next       = '0;
        tok_next.kind  = TK_NONE;
        tok_next.last  = s_data.end_of_expr;
        tok_next.digit = 4'(s_data.char_code - CH_ZERO);
        priority if (s_data.char_code == CH_LPAR) begin
            tok_next.kind = TK_LPAR;
        end else if (s_data.char_code == CH_RPAR) begin
            tok_next.kind = TK_RPAR;
        end else if (s_data.char_code == CH_ADD) begin
            tok_next.kind = TK_OP;
            tok_next.op   = OP_ADD;
        end else if (s_data.char_code == CH_SUB) begin
            tok_next.kind = TK_OP;
            tok_next.op   = OP_SUB;
        end else if (s_data.char_code == CH_MUL) begin
            tok_next.kind = TK_OP;
            tok_next.op   = OP_MUL;
        end else if (s_data.char_code == CH_DIV) begin
            tok_next.kind = TK_OP;
            tok_next.op   = OP_DIV;
        end else if (s_data.char_code >= CH_ZERO && s_data.char_code <= CH_NINE) begin
            tok_next.kind = TK_DIGIT;
        end else begin
            tok_next.kind = TK_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            tok_reg <= tok_next;
        end
    end
endmodule

FILE: rtl/iee_queue.sv
// Small token queue between the front end and the execution engine.
// Depends on iee_pkg.
module iee_queue #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            w_valid,
    output logic            w_ready,
    input  iee_pkg::token_t w_data,
    output logic            r_valid,
    input  logic            r_ready,
    output iee_pkg::token_t r_data
);
    import iee_pkg::*;

    localparam int AW = $clog2(DEPTH);

    token_t          mem_reg [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;

    assign w_ready = cnt_reg != (AW+1)'(DEPTH);
    assign r_valid = cnt_reg != '0;
    assign r_data  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (w_valid && w_ready) begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (r_valid && r_ready) begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(w_valid && w_ready) - (AW+1)'(r_valid && r_ready);
        end
        if (w_valid && w_ready) begin
            mem_reg[wp_reg] <= w_data;
        end
    end
endmodule

FILE: rtl/iee_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing outside itself.
module iee_divider #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, d_reg;
    logic [W:0]    r_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, neg_reg, done_reg;
    logic [W:0]    trial;

    assign trial    = {r_reg[W-1:0], q_reg[W-1]} - {1'b0, d_reg};
    assign done     = done_reg;
    assign quotient = neg_reg ? (W)'(-q_reg) : q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
                r_reg    <= '0;
                q_reg    <= dividend[W-1] ? (W)'(-dividend) : dividend;
                d_reg    <= divisor[W-1] ? (W)'(-divisor) : divisor;
                neg_reg  <= dividend[W-1] ^ divisor[W-1];
            end else if (busy_reg) begin
                if (!trial[W]) begin
                    r_reg <= trial;
                    q_reg <= {q_reg[W-2:0], 1'b1};
                end else begin
                    r_reg <= {r_reg[W-1:0], q_reg[W-1]};
                    q_reg <= {q_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: rtl/iee_engine.sv
// Execution engine: operator and value stacks, reduction sequencer, result register.
// Depends on iee_pkg and iee_divider.
module iee_engine #(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               t_valid,
    output logic               t_ready,
    input  iee_pkg::token_t    t_data,
    output logic               m_valid,
    input  logic               m_ready,
    output iee_pkg::out_item_t m_data
);
    import iee_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int W  = VALUE_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_RED_RD, S_RED_EX, S_DIV_WAIT, S_FINAL, S_EMIT
    } state_t;

    // Why a reduction is running decides where the sequencer returns.
    typedef enum logic [1:0] { R_OP, R_RPAR, R_END } red_mode_t;

    state_t        state_reg;
    red_mode_t     mode_reg;
    token_t        tok_reg;
    logic [W-1:0]  vstack [STACK_DEPTH];
    logic [2:0]    ostack [STACK_DEPTH];
    logic [CW-1:0] vcnt_reg, ocnt_reg;
    logic [2:0]    otop_reg;
    logic [1:0]    err_reg;
    logic [W-1:0]  lhs_reg, rhs_reg, rd_data_reg;
    logic [2:0]    rop_reg;
    logic          out_valid_reg;
    out_item_t     out_reg;
    logic          div_start, div_done;
    logic [W-1:0]  div_q;
    logic [W-1:0]  prod;
    logic [AW-1:0] vtop_idx, otop_idx;

    assign vtop_idx = AW'(vcnt_reg - 1'b1);
    assign otop_idx = AW'(ocnt_reg - 1'b1);
    assign prod     = W'(lhs_reg * rhs_reg);
    assign div_start = (state_reg == S_RED_EX) && (rop_reg == OP_DIV) && (rhs_reg != '0);

    iee_divider #(.W(W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(lhs_reg), .divisor(rhs_reg), .done(div_done), .quotient(div_q)
    );

    // A waiting result only holds the emit step, so new tokens keep flowing meanwhile.
    assign t_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            vcnt_reg      <= '0;
            ocnt_reg      <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (t_valid && t_ready) begin
                        tok_reg   <= t_data;
                        state_reg <= S_DISPATCH;
                        otop_reg  <= ostack[otop_idx];
                    end
                end
                S_DISPATCH: begin
                    state_reg <= tok_reg.last ? S_FINAL : S_IDLE;
                    if (err_reg == ST_OK) begin
                        unique case (tok_reg.kind)
                            TK_DIGIT: begin
                                if (vcnt_reg == CW'(STACK_DEPTH)) begin
                                    err_reg <= ST_OVF;
                                end else begin
                                    vstack[AW'(vcnt_reg)] <= W'(tok_reg.digit);
                                    vcnt_reg <= vcnt_reg + 1'b1;
                                end
                            end
                            TK_LPAR: begin
                                if (ocnt_reg == CW'(STACK_DEPTH)) begin
                                    err_reg <= ST_OVF;
                                end else begin
                                    ostack[AW'(ocnt_reg)] <= OP_LPAR;
                                    ocnt_reg <= ocnt_reg + 1'b1;
                                end
                            end
                            TK_OP: begin
                                if (ocnt_reg != '0 && otop_reg != OP_LPAR &&
                                    (op_high(otop_reg) || !op_high(tok_reg.op))) begin
                                    mode_reg  <= R_OP;
                                    state_reg <= S_RED_RD;
                                end else if (ocnt_reg == CW'(STACK_DEPTH)) begin
                                    err_reg <= ST_OVF;
                                end else begin
                                    ostack[AW'(ocnt_reg)] <= tok_reg.op;
                                    ocnt_reg <= ocnt_reg + 1'b1;
                                end
                            end
                            TK_RPAR: begin
                                if (ocnt_reg == '0) begin
                                    err_reg <= ST_BAD;
                                end else if (otop_reg == OP_LPAR) begin
                                    ocnt_reg <= ocnt_reg - 1'b1;
                                end else begin
                                    mode_reg  <= R_RPAR;
                                    state_reg <= S_RED_RD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RED_RD: begin
                    // Pop operator and top two values.
                    if (vcnt_reg < CW'(2)) begin
                        err_reg   <= ST_BAD;
                        state_reg <= tok_reg.last ? S_FINAL : S_IDLE;
                    end else begin
                        rop_reg   <= otop_reg;
                        rhs_reg   <= vstack[vtop_idx];
                        lhs_reg   <= vstack[AW'(vcnt_reg - CW'(2))];
                        ocnt_reg  <= ocnt_reg - 1'b1;
                        vcnt_reg  <= vcnt_reg - CW'(2);
                        state_reg <= S_RED_EX;
                    end
                end
                S_RED_EX: begin
                    unique case (rop_reg)
                        OP_ADD: rd_data_reg <= lhs_reg + rhs_reg;
                        OP_SUB: rd_data_reg <= lhs_reg - rhs_reg;
                        OP_MUL: rd_data_reg <= prod;
                        default: rd_data_reg <= '0;
                    endcase
                    if (rop_reg == OP_DIV && rhs_reg == '0) begin
                        err_reg   <= ST_DIV0;
                        state_reg <= tok_reg.last ? S_FINAL : S_IDLE;
                    end else if (rop_reg == OP_DIV) begin
                        state_reg <= S_DIV_WAIT;
                    end else if (rop_reg == OP_LPAR || rop_reg > OP_DIV) begin
                        err_reg   <= ST_BAD;
                        state_reg <= tok_reg.last ? S_FINAL : S_IDLE;
                    end else begin
                        state_reg <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT: begin
                    if (rop_reg != OP_DIV || div_done) begin
                        // Push the reduced value; two were popped so it always fits.
                        vstack[AW'(vcnt_reg)] <= (rop_reg == OP_DIV) ? div_q : rd_data_reg;
                        vcnt_reg  <= vcnt_reg + 1'b1;
                        otop_reg  <= ostack[AW'(ocnt_reg - 1'b1)];
                        unique case (mode_reg)
                            R_END:   state_reg <= S_FINAL;
                            default: state_reg <= S_DISPATCH;
                        endcase
                    end
                end
                S_FINAL: begin
                    otop_reg <= ostack[otop_idx];
                    if (err_reg == ST_OK && ocnt_reg != '0) begin
                        if (ostack[otop_idx] == OP_LPAR) begin
                            err_reg <= ST_BAD;
                        end else begin
                            mode_reg  <= R_END;
                            state_reg <= S_RED_RD;
                        end
                    end else begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!out_valid_reg) begin
                        if (err_reg == ST_OK && vcnt_reg != CW'(1)) begin
                            out_reg.status       <= ST_BAD;
                            out_reg.result_value <= '0;
                        end else begin
                            out_reg.status       <= err_reg;
                            out_reg.result_value <= (err_reg == ST_OK) ?
                                32'(signed'(vstack[0])) : '0;
                        end
                        out_valid_reg <= 1'b1;
                        vcnt_reg      <= '0;
                        ocnt_reg      <= '0;
                        err_reg       <= ST_OK;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/infix_expression_evaluator.sv
// Top level of the infix expression evaluator.
// Depends on iee_pkg, iee_front, iee_queue and iee_engine.
//
// Characters enter one per item; digits, + - * /, and parentheses are evaluated with
// normal precedence, everything else is ignored. The item flagged end_of_expr closes
// the expression and yields one result with a status (0 ok, 1 divide by zero, 2 stack
// overflow, 3 malformed). A front stage classifies characters into a four-entry queue;
// the engine takes the next token only once it is back in its idle state, so tokens
// wait while reductions run, a division waits for the serial divider, and the end
// of an expression runs the remaining reductions before the result is emitted.
module infix_expression_evaluator #(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  iee_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output iee_pkg::out_item_t m_data
);
    import iee_pkg::*;

    logic   f_valid, f_ready, q_valid, q_ready;
    token_t f_tok, q_tok;

    iee_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .t_valid(f_valid), .t_ready(f_ready), .t_data(f_tok)
    );

    iee_queue #(.DEPTH(4)) u_queue (
        .aclk(aclk), .aresetn(aresetn), .w_valid(f_valid), .w_ready(f_ready),
        .w_data(f_tok), .r_valid(q_valid), .r_ready(q_ready), .r_data(q_tok)
    );

    iee_engine #(.STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_engine (
        .aclk(aclk), .aresetn(aresetn), .t_valid(q_valid), .t_ready(q_ready),
        .t_data(q_tok), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule
